@@ design/upd_pkg.sv @@
// Package for the URL percent-decoder: payload structs, the request bundle
// passed from front to back, the escape-tracking enum and hex helpers.
// No dependencies.
package upd_pkg;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    localparam int BUNDLE_MAX    = 3;
    localparam int QUEUE_DEPTH   = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } raw_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } dec_t;

    typedef struct packed {
        logic [1:0]                      count;
        logic [BUNDLE_MAX-1:0][7:0]      data;
        logic                            last;
    } bundle_t;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_PCT,
        PEND_DIGIT
    } pend_t;

    function automatic logic is_hex(input logic [7:0] b);
        is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
                 (b >= 8'h61 && b <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
        begin
            hex_value = b[3:0];
        end
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
        begin
            hex_value = b[3:0] + 4'd9;
        end
        else
        begin
            hex_value = 4'd0;
        end
    endfunction

endpackage

@@ design/url_percent_decoder.sv @@
// Top level of the streaming URL percent-decoder: front part, bundle queue
// and back part. Depends on upd_pkg, upd_front, upd_queue, upd_back.
//
//   channel   | handshake            | payload
//   ----------+----------------------+------------------------------
//   raw       | raw_valid/raw_stall  | raw_t: in_byte, in_last
//   dec       | dec_valid/dec_stall  | dec_t: out_byte, run_last, string_end
//   cfg       | cfg_wen              | cfg_wdata: plus_as_space
//
// One request is taken per cycle while the queue has room; a request yields
// 0 to 3 bytes and the back part sends one byte per cycle unless dec is
// stalled. The first byte of a request passes through the bundle queue,
// the current-bundle register and the output register to reach dec.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stall on dec holds the output register; raw_stall rises once the
// QUEUE_DEPTH bundle queue is full.
module url_percent_decoder
    import upd_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic raw_valid,
    output logic raw_stall,
    input  raw_t raw,
    output logic dec_valid,
    input  logic dec_stall,
    output dec_t dec,
    input  logic cfg_wen,
    input  logic cfg_wdata
);

    logic    push;
    bundle_t push_data;
    logic    pop;
    bundle_t head;
    logic    q_empty;
    logic    q_full;

    upd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw_valid),
        .raw_stall (raw_stall),
        .raw       (raw),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    upd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .dec_valid (dec_valid),
        .dec_stall (dec_stall),
        .dec       (dec)
    );

endmodule

@@ design/upd_front.sv @@
// Front part of the decoder: accepts raw bytes, tracks the pending escape
// and turns each request into a bundle of up to three decoded bytes.
// Depends on upd_pkg.
module upd_front
    import upd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    raw_valid,
    output logic    raw_stall,
    input  raw_t    raw,
    input  logic    cfg_wen,
    input  logic    cfg_wdata,
    input  logic    q_full,
    output logic    push,
    output bundle_t push_data
);

    pend_t                     pend_reg;
    pend_t                     pend_next;
    pend_t                     pend_step;
    logic [7:0]                fd_reg;
    logic [7:0]                fd_next;
    logic [7:0]                fd_step;
    logic                      plus_reg;
    logic                      accept;
    logic                      idle_run;
    logic [1:0]                n;
    logic [BUNDLE_MAX-1:0][7:0] e;

    assign raw_stall = q_full;
    assign accept    = raw_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= PEND_NONE;
            plus_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (cfg_wen)
            begin
                plus_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fd_reg <= fd_next;
    end

    always_comb
    begin
        e         = '0;
        n         = 2'd0;
        pend_step = pend_reg;
        fd_step   = fd_reg;
        idle_run  = 1'b0;
        case (pend_reg)
            PEND_PCT:
            begin
                if (is_hex(raw.in_byte))
                begin
                    fd_step   = raw.in_byte;
                    pend_step = PEND_DIGIT;
                end
                else
                begin
                    e[0]     = PCT_CHAR;
                    n        = 2'd1;
                    idle_run = 1'b1;
                end
            end
            PEND_DIGIT:
            begin
                if (is_hex(raw.in_byte))
                begin
                    e[0]      = {hex_value(fd_reg), hex_value(raw.in_byte)};
                    n         = 2'd1;
                    pend_step = PEND_NONE;
                end
                else
                begin
                    e[0]     = PCT_CHAR;
                    e[1]     = fd_reg;
                    n        = 2'd2;
                    idle_run = 1'b1;
                end
            end
            default:
            begin
                idle_run = 1'b1;
            end
        endcase

        if (idle_run)
        begin
            if (raw.in_byte == PCT_CHAR)
            begin
                pend_step = PEND_PCT;
            end
            else
            begin
                e[n]      = (raw.in_byte == PLUS_CHAR && plus_reg) ? SPACE_CHAR
                                                                   : raw.in_byte;
                n         = n + 2'd1;
                pend_step = PEND_NONE;
            end
        end

        // flush held bytes at end of string
        if (raw.in_last)
        begin
            case (pend_step)
                PEND_PCT:
                begin
                    e[n] = PCT_CHAR;
                    n    = n + 2'd1;
                end
                PEND_DIGIT:
                begin
                    e[0] = PCT_CHAR;
                    e[1] = fd_step;
                    n    = 2'd2;
                end
                default:
                begin
                end
            endcase
            pend_step = PEND_NONE;
        end

        pend_next = accept ? pend_step : pend_reg;
        fd_next   = accept ? fd_step : fd_reg;

        push_data.count = n;
        push_data.data  = e;
        push_data.last  = raw.in_last;
        push            = accept && (n != 2'd0);
    end

endmodule

@@ design/upd_queue.sv @@
// Short queue of request bundles between front and back parts.
// Register-based, one write and one read per cycle. Depends on upd_pkg.
module upd_queue
    import upd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output bundle_t head,
    output logic    empty,
    output logic    full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    bundle_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] wr_next;
    logic [PTR_W-1:0] rd_reg;
    logic [PTR_W-1:0] rd_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CNT_MAX);
    assign head  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_MAX) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_MAX) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

@@ design/upd_back.sv @@
// Back part of the decoder: hands out the bytes of queued bundles one per
// cycle, unless a dec stall holds the output register. Depends on upd_pkg.
module upd_back
    import upd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  bundle_t head,
    input  logic    q_empty,
    output logic    pop,
    output logic    dec_valid,
    input  logic    dec_stall,
    output dec_t    dec
);

    bundle_t    cur_reg;
    bundle_t    cur_next;
    logic       cur_valid_reg;
    logic       cur_valid_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    dec_t       out_reg;
    dec_t       out_next;
    logic       out_free;
    logic       emit;
    logic       final_elem;
    logic       load_cur;

    assign out_free   = !out_valid_reg || !dec_stall;
    assign emit       = cur_valid_reg && out_free;
    assign final_elem = (idx_reg == cur_reg.count - 2'd1);
    assign load_cur   = (!cur_valid_reg || (emit && final_elem)) && !q_empty;
    assign pop        = load_cur;
    assign dec_valid  = out_valid_reg;
    assign dec        = out_reg;

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load_cur)
        begin
            cur_next       = head;
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 2'd1;
            if (final_elem)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (out_free)
        begin
            out_valid_next = cur_valid_reg;
        end
        if (emit)
        begin
            out_next.out_byte   = cur_reg.data[idx_reg];
            out_next.run_last   = final_elem;
            out_next.string_end = final_elem && cur_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> cur_reg.count != 2'd0)
        else $error("bundle in back part has no bytes");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> idx_reg < cur_reg.count)
        else $error("byte index past end of bundle");

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_reg.string_end || out_reg.run_last))
        else $error("string end on a byte that does not close its request");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule

@@ tb/url_percent_decoder_tb.sv @@
// Self-checking bench for url_percent_decoder: a directed request table and
// random encoded strings, checked against the table or an in-bench decoder model.
// Depends on upd_pkg and the url_percent_decoder RTL.
module url_percent_decoder_tb;
    import upd_pkg::*;

    localparam int ROWS       = 25;
    localparam int PHASE_B_AT = 18;

    logic clk;
    logic rst_n;
    logic raw_valid;
    logic raw_stall;
    raw_t raw;
    logic dec_valid;
    logic dec_stall;
    dec_t dec;
    logic cfg_wen;
    logic cfg_wdata;

    url_percent_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw_valid),
        .raw_stall (raw_stall),
        .raw       (raw),
        .dec_valid (dec_valid),
        .dec_stall (dec_stall),
        .dec       (dec),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    pend_t      esc_state;
    logic [7:0] held_digit;
    logic       plus_mode;
    dec_t       fresh_q[$];
    dec_t       decoded_q[$];
    int         idle_pct;
    int         errors;

    raw_t       row_req [0:ROWS-1];
    int         row_n   [0:ROWS-1];
    logic [7:0] row_res [0:ROWS-1][0:2];
    int         row_fill;

    always #5 clk = ~clk;

    function automatic bit hex_ok(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] b);
        if (b >= "0" && b <= "9")
        begin
            return 4'(b - "0");
        end
        else if (b >= "A" && b <= "F")
        begin
            return 4'(b - "A" + 10);
        end
        else if (b >= "a" && b <= "f")
        begin
            return 4'(b - "a" + 10);
        end
        return 4'd0;
    endfunction

    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10)
        begin
            return 8'(8'h30 + v);
        end
        else if (v < 16)
        begin
            return 8'(8'h41 + v - 10);
        end
        return 8'(8'h61 + v - 16);
    endfunction

    function automatic logic [7:0] rand_nonhex();
        logic [7:0] b;
        b = 8'($urandom);
        while (hex_ok(b))
        begin
            b = 8'($urandom);
        end
        return b;
    endfunction

    function automatic void plain_byte(input logic [7:0] b, ref logic [7:0] outs[$]);
        if (b == PCT_CHAR)
        begin
            esc_state = PEND_PCT;
        end
        else if (b == PLUS_CHAR && plus_mode)
        begin
            outs = {outs, SPACE_CHAR};
        end
        else
        begin
            outs = {outs, b};
        end
    endfunction

    task automatic decode_request(input raw_t r);
        logic [7:0] outs[$];
        logic [7:0] pair;
        dec_t       e;
        int         k;
        case (esc_state)
            PEND_PCT:
            begin
                if (hex_ok(r.in_byte))
                begin
                    held_digit = r.in_byte;
                    esc_state  = PEND_DIGIT;
                end
                else
                begin
                    outs      = {outs, PCT_CHAR};
                    esc_state = PEND_NONE;
                    plain_byte(r.in_byte, outs);
                end
            end
            PEND_DIGIT:
            begin
                esc_state = PEND_NONE;
                if (hex_ok(r.in_byte))
                begin
                    pair = {nibble_of(held_digit), nibble_of(r.in_byte)};
                    outs = {outs, pair};
                end
                else
                begin
                    outs = {outs, PCT_CHAR};
                    outs = {outs, held_digit};
                    plain_byte(r.in_byte, outs);
                end
            end
            default:
            begin
                esc_state = PEND_NONE;
                plain_byte(r.in_byte, outs);
            end
        endcase
        if (r.in_last)
        begin
            if (esc_state == PEND_PCT)
            begin
                outs = {outs, PCT_CHAR};
            end
            else if (esc_state == PEND_DIGIT)
            begin
                outs = {outs, PCT_CHAR};
                outs = {outs, held_digit};
            end
            esc_state = PEND_NONE;
        end
        while (outs.size() > 3)
        begin
            void'(outs.pop_back());
        end
        fresh_q.delete();
        for (k = 0; k < outs.size(); k++)
        begin
            e.out_byte   = outs[k];
            e.run_last   = (k == outs.size() - 1);
            e.string_end = e.run_last && r.in_last;
            fresh_q      = {fresh_q, e};
        end
    endtask

    task automatic add_row(input logic [7:0] b, input bit last, input int n,
                           input logic [7:0] e0, input logic [7:0] e1, input logic [7:0] e2);
        row_req[row_fill].in_byte = b;
        row_req[row_fill].in_last = last;
        row_n[row_fill]           = n;
        row_res[row_fill][0]      = e0;
        row_res[row_fill][1]      = e1;
        row_res[row_fill][2]      = e2;
        row_fill++;
    endtask

    task automatic push_request(input raw_t r, input int row);
        dec_t e;
        int   k;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            raw_valid <= 1'b0;
            @(negedge clk);
        end
        raw       <= r;
        raw_valid <= 1'b1;
        @(posedge clk);
        while (raw_stall)
        begin
            @(posedge clk);
        end
        decode_request(r);
        if (row >= 0 && row_n[row] >= 0)
        begin
            fresh_q.delete();
            for (k = 0; k < row_n[row]; k++)
            begin
                e.out_byte   = row_res[row][k];
                e.run_last   = (k == row_n[row] - 1);
                e.string_end = e.run_last && r.in_last;
                fresh_q      = {fresh_q, e};
            end
        end
        decoded_q = {decoded_q, fresh_q};
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (decoded_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic write_plus_mode(input logic v);
        wait_drained();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        plus_mode = v;
    endtask

    task automatic random_strings(input int count);
        logic [7:0] str[$];
        raw_t       r;
        int         sent;
        int         len;
        int         pick;
        int         j;
        sent = 0;
        while (sent < count)
        begin
            str.delete();
            len = $urandom_range(1, 6);
            for (j = 0; j < len; j++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    str = {str, PCT_CHAR};
                    str = {str, rand_hex()};
                    str = {str, rand_hex()};
                end
                else if (pick < 45)
                begin
                    str = {str, PLUS_CHAR};
                end
                else if (pick < 55)
                begin
                    str = {str, PCT_CHAR};
                    if ($urandom_range(0, 1))
                    begin
                        str = {str, rand_hex()};
                    end
                    if ($urandom_range(0, 3) != 0)
                    begin
                        str = {str, rand_nonhex()};
                    end
                end
                else
                begin
                    str = {str, 8'($urandom)};
                end
            end
            for (j = 0; j < str.size(); j++)
            begin
                r.in_byte = str[j];
                r.in_last = (j == str.size() - 1);
                push_request(r, -1);
                sent++;
            end
        end
        raw_valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        dec_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    always @(posedge clk)
    begin
        dec_t want;
        if (rst_n && dec_valid && !dec_stall)
        begin
            if (decoded_q.size() == 0)
            begin
                $display("%0t: unexpected byte %02h run_last %b string_end %b",
                         $time, dec.out_byte, dec.run_last, dec.string_end);
                errors++;
            end
            else
            begin
                want = decoded_q.pop_front();
                if (dec.out_byte !== want.out_byte)
                begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.out_byte, dec.out_byte);
                    errors++;
                end
                if (dec.run_last !== want.run_last)
                begin
                    $display("%0t: run_last expected %b actual %b",
                             $time, want.run_last, dec.run_last);
                    errors++;
                end
                if (dec.string_end !== want.string_end)
                begin
                    $display("%0t: string_end expected %b actual %b",
                             $time, want.string_end, dec.string_end);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #3000000;
        $display("url_percent_decoder_tb: FAIL");
        $finish;
    end

    initial
    begin
        int i;
        int waited;
        clk        = 1'b0;
        rst_n      = 1'b0;
        raw_valid  = 1'b0;
        raw        = '0;
        cfg_wen    = 1'b0;
        cfg_wdata  = 1'b0;
        esc_state  = PEND_NONE;
        held_digit = 8'h00;
        plus_mode  = 1'b0;
        idle_pct   = 32;
        errors     = 0;
        row_fill   = 0;

        add_row(8'h00, 1'b1, 1, 8'h00, 8'h00, 8'h00);
        add_row(8'hFF, 1'b1, 1, 8'hFF, 8'h00, 8'h00);
        add_row("+",   1'b0, 1, PLUS_CHAR, 8'h00, 8'h00);
        add_row("%",   1'b0, 0, 8'h00, 8'h00, 8'h00);
        add_row("4",   1'b0, 0, 8'h00, 8'h00, 8'h00);
        add_row("1",   1'b1, 1, 8'h41, 8'h00, 8'h00);
        add_row("%",   1'b0, 0, 8'h00, 8'h00, 8'h00);
        add_row("a",   1'b0, 0, 8'h00, 8'h00, 8'h00);
        add_row("F",   1'b0, -1, 8'h00, 8'h00, 8'h00);
        add_row("%",   1'b0, 0, 8'h00, 8'h00, 8'h00);
        add_row("G",   1'b0, 2, PCT_CHAR, "G", 8'h00);
        add_row("%",   1'b0, 0, 8'h00, 8'h00, 8'h00);
        add_row("9",   1'b0, -1, 8'h00, 8'h00, 8'h00);
        add_row("z",   1'b0, -1, 8'h00, 8'h00, 8'h00);
        add_row("%",   1'b0, 0, 8'h00, 8'h00, 8'h00);
        add_row("%",   1'b0, 1, PCT_CHAR, 8'h00, 8'h00);
        add_row("0",   1'b1, -1, 8'h00, 8'h00, 8'h00);
        add_row("%",   1'b1, 1, PCT_CHAR, 8'h00, 8'h00);
        add_row("+",   1'b1, 1, SPACE_CHAR, 8'h00, 8'h00);
        add_row("%",   1'b0, 0, 8'h00, 8'h00, 8'h00);
        add_row("+",   1'b1, -1, 8'h00, 8'h00, 8'h00);
        add_row("%",   1'b0, 0, 8'h00, 8'h00, 8'h00);
        add_row("c",   1'b0, 0, 8'h00, 8'h00, 8'h00);
        add_row("%",   1'b1, -1, 8'h00, 8'h00, 8'h00);
        add_row(8'h80, 1'b1, -1, 8'h00, 8'h00, 8'h00);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < ROWS; i++)
        begin
            if (i == PHASE_B_AT)
            begin
                raw_valid <= 1'b0;
                write_plus_mode(1'b1);
            end
            push_request(row_req[i], i);
        end
        raw_valid <= 1'b0;

        write_plus_mode(1'b0);
        random_strings(100);
        write_plus_mode(1'b1);
        random_strings(100);
        idle_pct = 0;
        @(negedge clk);
        random_strings(100);
        idle_pct = 32;
        write_plus_mode(1'b0);
        random_strings(100);
        write_plus_mode(1'b1);
        random_strings(100);

        waited = 0;
        while (decoded_q.size() != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        if (decoded_q.size() != 0)
        begin
            $display("%0t: timeout with %0d bytes outstanding", $time, decoded_q.size());
            $display("url_percent_decoder_tb: FAIL");
            $finish;
        end
        else
        begin
            repeat (10) @(negedge clk);
            if (decoded_q.size() != 0)
            begin
                $display("%0t: %0d bytes never arrived", $time, decoded_q.size());
                errors++;
            end
            if (errors == 0)
            begin
                $display("url_percent_decoder_tb: PASS");
            end
            else
            begin
                $display("url_percent_decoder_tb: FAIL");
            end
            $finish;
        end
    end

endmodule
